[rtl/byte_frequency_rank_top_assert.svh]
// Assertion macros used by the port-level checker.
`ifndef BYTE_FREQUENCY_RANK_TOP_ASSERT_SVH
`define BYTE_FREQUENCY_RANK_TOP_ASSERT_SVH

// Condition must hold at every edge outside reset.
`define BFR_ASSERT_NOW(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("bfr assertion failed");

// Antecedent implies consequent in the same cycle.
`define BFR_ASSERT_IMP(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("bfr assertion failed");

// Antecedent implies consequent in the next cycle.
`define BFR_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("bfr assertion failed");

`endif

[rtl/bfr_pkg.sv]
// Package with the constants and types of the byte frequency ranker.
package bfr_pkg;

   localparam int COUNT_BITS = 16;
   localparam int ALPHABET   = 256;
   localparam int SYM_BITS   = 8;
   localparam int OCC_BITS   = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // Request kinds carried on req_tuser
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_PULL = 1'b1;

   // Broadcast control from the top level to every cell
   typedef struct packed {
      logic                load;
      logic [SYM_BITS-1:0] load_sym;
      logic                clear;
      logic [SYM_BITS-1:0] clear_sym;
   } ctl_type;

   // Candidate carried along the chain during a scan
   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [SYM_BITS-1:0]   sym;
      logic                  nz_one;
      logic                  nz_two;
   } cand_type;

   function automatic logic [OCC_BITS-1:0] sat_occ(input logic [COUNT_BITS-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      if (wide > 32'(COUNT_MAX) || wide > 32'hFFFF) begin
         wide = (wide > 32'hFFFF) ? 32'hFFFF : wide;
      end
      return wide[OCC_BITS-1:0];
   endfunction

endpackage

[rtl/bfr_cell.sv]
// One histogram cell: a saturating counter and one stage of the ranking chain.
module bfr_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bfr_pkg::SYM_BITS-1:0]  cell_sym,
   input  bfr_pkg::ctl_type              ctl,
   input  logic                          cand_valid_in,
   input  bfr_pkg::cand_type             cand_in,
   output logic                          cand_valid_out,
   output bfr_pkg::cand_type             cand_out
);

   logic [bfr_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic                           valid_ff;
   bfr_pkg::cand_type              cand_ff, cand_nx;
   logic                           nonzero;
   logic                           better;

   always_comb begin
      count_in = count_ff;
      if (ctl.clear && ctl.clear_sym == cell_sym) begin
         count_in = '0;
      end else if (ctl.load && ctl.load_sym == cell_sym && count_ff != bfr_pkg::COUNT_MAX) begin
         count_in = count_ff + 1'b1;
      end
   end

   // strict compare keeps the lower symbol on a tie
   assign nonzero = (count_ff != '0);
   assign better  = (count_ff > cand_in.count);

   always_comb begin
      cand_nx        = cand_in;
      cand_nx.nz_one = cand_in.nz_one | nonzero;
      cand_nx.nz_two = cand_in.nz_two | (cand_in.nz_one & nonzero);
      if (better) begin
         cand_nx.count = count_ff;
         cand_nx.sym   = cell_sym;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= cand_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cand_valid_in) begin
         cand_ff <= cand_nx;
      end
   end

   assign cand_valid_out = valid_ff;
   assign cand_out       = cand_ff;

endmodule

[rtl/byte_frequency_rank_top.sv]
// Top level of the byte frequency ranker: cell row, control and output register.
//
// Byte histogram with ranked readout. A load request (req_tuser = 0) counts
// the byte in req_tdata; loads stream at one per cycle while no pull scan runs.
// A pull request (req_tuser = 1) sends a candidate wave down the row of
// ALPHABET cells, one cell per cycle; the next request is taken only after
// the wave has left the last cell. The winning entry is cleared as its
// response is registered. A pull is only taken once the previous response
// has left the output register; loads are taken meanwhile.
module byte_frequency_rank_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // symbol[7:0]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // ranked_symbol[7:0], occurrences[23:8]
   output logic        rsp_tlast,   // final_res
   output logic        rsp_tuser    // empty_res
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff;
   logic        rsp_last_ff;
   logic        rsp_empty_ff;

   logic req_acc, pull_acc, tail_valid, tail_hit;
   bfr_pkg::ctl_type  ctl;
   bfr_pkg::cand_type tail;

   logic              chain_valid [bfr_pkg::ALPHABET+1];
   bfr_pkg::cand_type chain       [bfr_pkg::ALPHABET+1];

   assign req_tready = (state_ff == ST_IDLE) &&
                       (!rsp_valid_ff || req_tuser == bfr_pkg::KIND_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign pull_acc   = req_acc && req_tuser == bfr_pkg::KIND_PULL;

   assign tail_valid = chain_valid[bfr_pkg::ALPHABET];
   assign tail       = chain[bfr_pkg::ALPHABET];
   assign tail_hit   = tail_valid && tail.count != '0;

   always_comb begin
      ctl.load      = req_acc && req_tuser == bfr_pkg::KIND_LOAD;
      ctl.load_sym  = req_tdata;
      ctl.clear     = tail_hit;
      ctl.clear_sym = tail.sym;
   end

   assign chain_valid[0] = pull_acc;
   assign chain[0]       = '0;

   for (genvar i = 0; i < bfr_pkg::ALPHABET; i++) begin : g_cell
      bfr_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .cell_sym       (bfr_pkg::SYM_BITS'(i)),
         .ctl            (ctl),
         .cand_valid_in  (chain_valid[i]),
         .cand_in        (chain[i]),
         .cand_valid_out (chain_valid[i+1]),
         .cand_out       (chain[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pull_acc) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail_valid) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (tail_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // empty store gives all-zero fields with the empty flag
   always_ff @(posedge clock) begin
      if (tail_valid) begin
         if (tail_hit) begin
            rsp_data_ff  <= {bfr_pkg::sat_occ(tail.count), tail.sym};
            rsp_last_ff  <= !tail.nz_two;
            rsp_empty_ff <= 1'b0;
         end else begin
            rsp_data_ff  <= '0;
            rsp_last_ff  <= 1'b0;
            rsp_empty_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;

endmodule

[rtl/bfr_checker.sv]
// Port-level checker for the byte frequency ranker, bound to the top level.
`include "byte_frequency_rank_top_assert.svh"

module bfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,   // kind
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,   // ranked_symbol[7:0], occurrences[23:8]
   input logic        rsp_tlast,   // final_res
   input logic        rsp_tuser    // empty_res
);

   // empty response carries nothing else
   `BFR_ASSERT_IMP(a_empty_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0 && !rsp_tlast)
   // a ranked byte always has a count
   `BFR_ASSERT_IMP(a_count_nonzero, rsp_tvalid && !rsp_tuser, rsp_tdata[23:8] != '0)
   // a pull blocks further requests while the scan runs
   `BFR_ASSERT_NEXT(a_pull_busy, req_tvalid && req_tready && req_tuser == bfr_pkg::KIND_PULL, !req_tready)
   // a new response only ends a scan, never follows an idle cycle
   `BFR_ASSERT_IMP(a_rsp_after_scan, $rose(rsp_tvalid), !$past(req_tready))
   `BFR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind byte_frequency_rank_top bfr_checker u_bfr_checker (.*);
